@@ src/dq_pkg.sv @@
// Shared types and constants for the double-ended queue core.
// Used by dq_ctrl and double_ended_queue_core; no dependencies.
package dq_pkg;

    localparam int DEPTH = 64;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int OP_W = 3;
    localparam int KEY_W = 32;
    localparam int STAT_W = 2;
    localparam int OCC_W = 7;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_CLEAR      = 3'd4
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [OP_W-1:0]         operation;
        logic signed [KEY_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic signed [KEY_W-1:0] popped_value;
        logic [OCC_W-1:0]        occupancy;
    } t_out_item;

    // Memory request from the pointer logic
    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [ADDR_W-1:0] addr;
        logic [KEY_W-1:0]  wdata;
    } t_mem_req;

    // Per-beat result information, known at accept time
    typedef struct packed {
        t_status          status;
        logic             pop_ok;
        logic [CNT_W-1:0] count;
    } t_res_info;

    // (base + off) mod DEPTH for base, off below DEPTH
    function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] base,
                                                   input logic [ADDR_W-1:0] off);
        logic [ADDR_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (ADDR_W + 1)'(DEPTH)) begin
            sum = sum - (ADDR_W + 1)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

@@ src/dq_ram.sv @@
// Simple dual-port synchronous RAM, one write and one registered read port.
// Generic; no package dependencies.
module dq_ram #(
    parameter int DEPTH_P = 64,
    parameter int WIDTH_P = 32,
    parameter int ADDR_P = (DEPTH_P > 1) ? $clog2(DEPTH_P) : 1
) (
    input  logic               i_clk,
    input  logic               i_wr_en,
    input  logic [ADDR_P-1:0]  i_wr_addr,
    input  logic [WIDTH_P-1:0] i_wr_data,
    input  logic               i_rd_en,
    input  logic [ADDR_P-1:0]  i_rd_addr,
    output logic [WIDTH_P-1:0] o_rd_data
);

    logic [WIDTH_P-1:0] r_mem [DEPTH_P];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

@@ src/dq_ctrl.sv @@
// Front pointer and count of the ring; issues at most one memory access per beat.
// Depends on dq_pkg.
module dq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  dq_pkg::t_in_item  i_item,
    output dq_pkg::t_mem_req  o_mem,
    output dq_pkg::t_res_info o_res
);
    import dq_pkg::*;

    logic [ADDR_W-1:0] r_front, n_front;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              full, empty;
    logic [ADDR_W-1:0] front_dec, front_inc;

    assign full  = (r_count == CNT_W'(DEPTH));
    assign empty = (r_count == '0);
    assign front_dec = (r_front == '0) ? ADDR_W'(DEPTH - 1) : r_front - 1'b1;
    assign front_inc = (r_front == ADDR_W'(DEPTH - 1)) ? '0 : r_front + 1'b1;

    always_comb begin
        n_front = r_front;
        n_count = r_count;
        o_mem.wr_en = 1'b0;
        o_mem.rd_en = 1'b0;
        o_mem.addr  = r_front;
        o_mem.wdata = i_item.value;
        o_res.status = ST_DONE;
        o_res.pop_ok = 1'b0;
        unique case (t_op'(i_item.operation))
            OP_PUSH_BACK: begin
                if (full) begin
                    o_res.status = ST_FULL;
                end else begin
                    o_mem.wr_en = 1'b1;
                    o_mem.addr  = ring_add(r_front, r_count[ADDR_W-1:0]);
                    n_count = r_count + 1'b1;
                end
            end
            OP_PUSH_FRONT: begin
                if (full) begin
                    o_res.status = ST_FULL;
                end else begin
                    o_mem.wr_en = 1'b1;
                    o_mem.addr  = front_dec;
                    n_front = front_dec;
                    n_count = r_count + 1'b1;
                end
            end
            OP_POP_FRONT: begin
                if (empty) begin
                    o_res.status = ST_EMPTY;
                end else begin
                    o_mem.rd_en = 1'b1;
                    o_res.pop_ok = 1'b1;
                    n_front = front_inc;
                    n_count = r_count - 1'b1;
                end
            end
            OP_POP_BACK: begin
                if (empty) begin
                    o_res.status = ST_EMPTY;
                end else begin
                    o_mem.rd_en = 1'b1;
                    o_mem.addr  = ring_add(r_front, ADDR_W'(r_count - 1'b1));
                    o_res.pop_ok = 1'b1;
                    n_count = r_count - 1'b1;
                end
            end
            OP_CLEAR: begin
                n_front = '0;
                n_count = '0;
            end
            default: begin
                // unused codes: no change
            end
        endcase
        o_mem.wr_en = o_mem.wr_en & i_accept;
        o_mem.rd_en = o_mem.rd_en & i_accept;
        o_res.count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

endmodule

@@ src/double_ended_queue_core.sv @@
// Bounded double-ended queue of 32-bit signed keys: a ring buffer in one RAM.
// Depends on dq_pkg, dq_ctrl and dq_ram.
//
// The block takes one operation per clock cycle while o_in_ready is high, and
// returns one result per operation: the cycle of acceptance updates the front
// pointer and count and issues the RAM write or read, and the result register
// captures the RAM read data once the output stage may advance. A write and a later
// read of the same entry fall on different clock edges, so no forwarding is
// needed. The RAM holds DEPTH keys; its contents are undefined after reset, and
// only entries written by a push are ever read. A push on a full queue reports
// full and is dropped; a pop on an empty queue reports empty. Stalls on the
// result side back up through the two stages to the input ready.
module double_ended_queue_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  dq_pkg::t_in_item  i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output dq_pkg::t_out_item o_out_item
);
    import dq_pkg::*;

    t_mem_req         mem_req;
    t_res_info        res_info;
    logic             accept;
    logic             out_adv;
    logic [KEY_W-1:0] rd_data;

    logic             r_s1_valid;
    t_res_info        r_s1_info;
    logic             r_out_valid;
    t_out_item        r_out_item;

    assign out_adv    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || out_adv;
    assign accept     = i_in_valid && o_in_ready;

    dq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_item  (i_in_item),
        .o_mem   (mem_req),
        .o_res   (res_info)
    );

    dq_ram #(
        .DEPTH_P(DEPTH),
        .WIDTH_P(KEY_W)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (mem_req.wr_en),
        .i_wr_addr(mem_req.addr),
        .i_wr_data(mem_req.wdata),
        .i_rd_en  (mem_req.rd_en),
        .i_rd_addr(mem_req.addr),
        .o_rd_data(rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= accept;
            end
            if (out_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_info <= res_info;
        end
        if (out_adv && r_s1_valid) begin
            r_out_item.status       <= r_s1_info.status;
            r_out_item.popped_value <= r_s1_info.pop_ok ? rd_data : '0;
            r_out_item.occupancy    <= OCC_W'(r_s1_info.count);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.occupancy <= OCC_W'(DEPTH)))
        else $error("occupancy beyond depth");

    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status == ST_FULL) |->
            (o_out_item.occupancy == OCC_W'(DEPTH)))
        else $error("full reported below depth");

    a_empty_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status == ST_EMPTY) |->
            (o_out_item.occupancy == '0 && o_out_item.popped_value == '0))
        else $error("empty result not clean");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_info.pop_ok && !out_adv) |=>
            (r_s1_valid && $stable(rd_data)))
        else $error("stalled read data lost");
`endif

endmodule
